### src/pal_pkg.sv
// shared types and constants for the positional array list
`timescale 1ns / 1ps

package pal_pkg;

  localparam int CAPACITY  = 8;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 4;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // one read and one write port into the slot file
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } store_req_t;

  // finished result handed to the output stage
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [DATA_W-1:0] rv;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

### src/pal_store.sv
// slot file of the list: one combinational read port, one write port
`timescale 1ns / 1ps

module pal_store (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pal_pkg::store_req_t               req_i,
  output logic [pal_pkg::DATA_W-1:0]        rd_data_o
);

  logic [pal_pkg::DATA_W-1:0] entries_q [pal_pkg::CAPACITY];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pal_pkg::CAPACITY; i++) begin
        entries_q[i] <= '0;
      end
    end else if (req_i.we) begin
      entries_q[req_i.waddr] <= req_i.wdata;
    end
  end

  assign rd_data_o = entries_q[req_i.raddr];

endmodule

### src/pal_seq.sv
// request sequencer: checks, then moves one slot per cycle; the last write waits until the result can be taken
`timescale 1ns / 1ps

module pal_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [pal_pkg::POS_W-1:0]         position_i,
  input  logic [pal_pkg::DATA_W-1:0]        value_i,
  input  logic                              res_free_i,
  input  logic [pal_pkg::DATA_W-1:0]        rd_data_i,
  output pal_pkg::store_req_t               req_o,
  output pal_pkg::result_t                  res_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN
  } state_e;

  state_e                          state_q, state_d;
  logic [pal_pkg::IDX_W-1:0]       pos_q, pos_d;
  logic [pal_pkg::IDX_W-1:0]       cursor_q, cursor_d;
  logic [pal_pkg::CNT_W-1:0]       count_q, count_d;
  logic [pal_pkg::DATA_W-1:0]      val_q, val_d;
  logic [pal_pkg::DATA_W-1:0]      rv_q, rv_d;

  pal_pkg::kind_e                  kind;
  logic                            accept;
  logic [pal_pkg::CMP_W-1:0]       pos_ext, cnt_ext;
  logic [pal_pkg::CNT_W-1:0]       cursor_next;
  logic                            last_step;

  assign kind        = pal_pkg::kind_e'(kind_i);
  assign pos_ext     = pal_pkg::CMP_W'(position_i);
  assign cnt_ext     = pal_pkg::CMP_W'(count_q);
  assign cursor_next = pal_pkg::CNT_W'(cursor_q) + pal_pkg::CNT_W'(1);
  assign last_step   = (cursor_next == count_q);

  assign in_stall_o = (state_q != S_IDLE) || !res_free_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cursor_d  = cursor_q;
    count_d   = count_q;
    val_d     = val_q;
    rv_d      = rv_q;
    req_o     = '0;
    res_o     = '0;
    res_o.status = pal_pkg::ST_OK;
    res_o.count  = count_q;

    case (state_q)
      S_IDLE: begin
        req_o.raddr = pal_pkg::IDX_W'(position_i);
        if (accept) begin
          pos_d = pal_pkg::IDX_W'(position_i);
          val_d = value_i;
          case (kind)
            pal_pkg::KIND_INSERT: begin
              if (count_q == pal_pkg::CNT_W'(pal_pkg::CAPACITY)) begin
                res_o.valid  = 1'b1;
                res_o.status = pal_pkg::ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                res_o.valid  = 1'b1;
                res_o.status = pal_pkg::ST_RANGE;
              end else begin
                cursor_d = pal_pkg::IDX_W'(count_q);
                state_d  = S_SHIFT_UP;
              end
            end
            pal_pkg::KIND_DELETE, pal_pkg::KIND_READ: begin
              if (count_q == '0) begin
                res_o.valid  = 1'b1;
                res_o.status = pal_pkg::ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                res_o.valid  = 1'b1;
                res_o.status = pal_pkg::ST_RANGE;
              end else if (kind == pal_pkg::KIND_READ) begin
                res_o.valid = 1'b1;
                res_o.rv    = rd_data_i;
              end else begin
                rv_d     = rd_data_i;
                cursor_d = pal_pkg::IDX_W'(position_i);
                state_d  = S_SHIFT_DN;
              end
            end
            default: begin
              res_o.valid  = 1'b1;
              res_o.status = pal_pkg::ST_RANGE;
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // walk down from the top, copying each slot one place up
        req_o.raddr = cursor_q - pal_pkg::IDX_W'(1);
        if (cursor_q != pos_q) begin
          req_o.we    = 1'b1;
          req_o.waddr = cursor_q;
          req_o.wdata = rd_data_i;
          cursor_d    = cursor_q - pal_pkg::IDX_W'(1);
        end else if (res_free_i) begin
          req_o.we    = 1'b1;
          req_o.waddr = pos_q;
          req_o.wdata = val_q;
          count_d     = count_q + pal_pkg::CNT_W'(1);
          res_o.valid = 1'b1;
          res_o.count = count_d;
          state_d     = S_IDLE;
        end
      end

      S_SHIFT_DN: begin
        // walk up from the hole, pulling each slot one place down
        req_o.raddr = pal_pkg::IDX_W'(cursor_next);
        if (!last_step) begin
          req_o.we    = 1'b1;
          req_o.waddr = cursor_q;
          req_o.wdata = rd_data_i;
          cursor_d    = pal_pkg::IDX_W'(cursor_next);
        end else if (res_free_i) begin
          req_o.we    = 1'b1;
          req_o.waddr = cursor_q;
          req_o.wdata = '0;
          count_d     = count_q - pal_pkg::CNT_W'(1);
          res_o.valid = 1'b1;
          res_o.rv    = rv_q;
          res_o.count = count_d;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rv_q  <= rv_d;
  end

endmodule

### src/positional_array_list_core.sv
// top level of the positional array list: sequencer, slot file, output stage
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------
//   request  | in_valid_i / in_stall_o   | kind_i, position_i, value_i
//   result   | out_valid_o / out_stall_i | status_o, read_value_o, count_o
//
// a read, or any request that fails its checks, is answered from the idle state
// an insert at position p moves the slots from p upward up one place, then
// writes the value at p; a delete moves the slots above p down one place and
// clears the top one; one slot moved per cycle via the read and write ports
// reset (async, active low) empties the list and clears every slot to zero
// a result beat waits in the output register while out_stall_i is high; the
// next request is taken as soon as that register is free or being emptied
`timescale 1ns / 1ps

module positional_array_list_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [pal_pkg::POS_W-1:0]         position_i,
  input  logic signed [pal_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic signed [pal_pkg::DATA_W-1:0] read_value_o,
  output logic [pal_pkg::CNT_OUT_W-1:0]     count_o
);

  pal_pkg::store_req_t           req;
  pal_pkg::result_t              res;
  logic [pal_pkg::DATA_W-1:0]    rd_data;
  logic                          res_free;

  logic                          out_valid_q;
  logic [1:0]                    status_q;
  logic [pal_pkg::DATA_W-1:0]    rv_q;
  logic [pal_pkg::CNT_OUT_W-1:0] count_q;

  // output register can take a beat when empty or when its beat leaves now
  assign res_free = !out_valid_q || !out_stall_i;

  pal_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .position_i (position_i),
    .value_i    (value_i),
    .res_free_i (res_free),
    .rd_data_i  (rd_data),
    .req_o      (req),
    .res_o      (res)
  );

  pal_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data)
  );

  // result beat holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload only moves when a new beat is loaded
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      rv_q     <= res.rv;
      count_q  <= pal_pkg::CNT_OUT_W'(res.count);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign read_value_o = rv_q;
  assign count_o      = count_q;

endmodule
